@@ rtl/skt_pkg.sv @@
// shared types and constants of the sorted key table
package skt_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned TagW     = 64;
  localparam int unsigned PosW     = 6;
  localparam int unsigned TotW     = 7;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 112;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  // result status carried in the output tuser
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_PUT  = 5'b00100,
    S_SCAN = 5'b01000,
    S_LIST = 5'b10000
  } state_e;

  // one stored table entry
  typedef struct packed {
    logic [TagW-1:0] name;
    logic [KeyW-1:0] key;
  } entry_t;

  // flags from the shared compare unit
  typedef struct packed {
    logic key_le;
    logic tag_eq;
  } cmp_res_t;

  // result payload except the entry total
  typedef struct packed {
    status_e         status;
    logic [PosW-1:0] pos;
    logic [KeyW-1:0] id;
    logic [TagW-1:0] name;
    logic            last;
  } out_t;

endpackage

@@ rtl/sorted_key_table_top.sv @@
// sorted key table: sequencer walking the entry memory through one compare unit
//
// Keeps up to CAPACITY entries (signed 32-bit id, 64-bit name tag) sorted by id
// in a single-port-read memory. The sequencer visits one entry per cycle through
// the shared compare unit, holding on the final step until the output register
// is free: insert walks down from the top entry, shifting each larger-or-equal
// entry up one slot until the gap is found; delete walks up from entry 0, finds
// the name and shifts the rest down in the same pass; search stops at the first
// match; list sends one result per cycle while the output side is ready. Full,
// empty and insert-into-empty cases finish in the accept cycle. The memory's
// single read port sets the one-entry-per-cycle pace. One item is in flight at a
// time; the input is ready only while the sequencer is idle and the output
// register can take a result.
module sorted_key_table_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // key_id [31:0], name_tag [95:32]
  input  logic [skt_pkg::InDataW-1:0]    s_axis_tdata,
  // op [1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // position [5:0], found_id [37:6], found_name [101:38], entry_total [108:102]
  output logic [skt_pkg::OutDataW-1:0]   m_axis_tdata,
  // status [1:0]
  output logic [1:0]                     m_axis_tuser,
  output logic                           m_axis_tlast
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);
  localparam int unsigned PadW = skt_pkg::OutDataW - skt_pkg::PosW - skt_pkg::KeyW
                                 - skt_pkg::TagW - skt_pkg::TotW;

  skt_pkg::state_e              state_q, state_d;
  logic [IW-1:0]                idx_q, idx_d;
  logic [CW-1:0]                count_q, count_d;
  skt_pkg::op_e                 op_q, op_d;
  logic [skt_pkg::KeyW-1:0]     key_q, key_d;
  logic [skt_pkg::TagW-1:0]     tag_q, tag_d;
  logic                         found_q, found_d;
  logic [IW-1:0]                hit_pos_q, hit_pos_d;
  skt_pkg::entry_t              hit_q, hit_d;
  logic                         m_valid_q, m_valid_d;
  skt_pkg::out_t                out_q, out_d;
  logic [skt_pkg::TotW-1:0]     tot_q, tot_d;

  logic                         s_accept;
  logic                         out_free;
  logic                         out_load;
  logic [IW-1:0]                last_idx;
  logic                         at_last;
  logic                         mem_we;
  logic [IW-1:0]                mem_waddr;
  skt_pkg::entry_t              mem_wdata;
  skt_pkg::entry_t              rdata;
  skt_pkg::entry_t              new_entry;
  skt_pkg::cmp_res_t            cmp;

  function automatic skt_pkg::out_t make_out(skt_pkg::status_e st,
                                             logic [IW-1:0] pos,
                                             skt_pkg::entry_t ent,
                                             logic lst);
    skt_pkg::out_t o;
    o.status = st;
    o.pos    = skt_pkg::PosW'(pos);
    o.id     = ent.key;
    o.name   = ent.name;
    o.last   = lst;
    return o;
  endfunction

  // handshake helpers
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == skt_pkg::S_IDLE) && out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign last_idx      = IW'(count_q - CW'(1));
  assign at_last       = (idx_q == last_idx);
  assign new_entry     = '{name: tag_q, key: key_q};

  // entry storage, read address follows the next index
  skt_mem #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_d),
    .rdata_o (rdata)
  );

  // shared compare unit
  skt_cmp u_cmp (
    .key_a_i (key_q),
    .key_b_i (rdata.key),
    .tag_a_i (tag_q),
    .tag_b_i (rdata.name),
    .res_o   (cmp)
  );

  // sequencer
  always_comb begin
    skt_pkg::entry_t in_entry;
    in_entry  = '{name: s_axis_tdata[95:32], key: s_axis_tdata[31:0]};
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    op_d      = op_q;
    key_d     = key_q;
    tag_d     = tag_q;
    found_d   = found_q;
    hit_pos_d = hit_pos_q;
    hit_d     = hit_q;
    out_d     = out_q;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = rdata;

    case (state_q)
      skt_pkg::S_IDLE: begin
        if (s_accept) begin
          op_d    = skt_pkg::op_e'(s_axis_tuser);
          key_d   = in_entry.key;
          tag_d   = in_entry.name;
          found_d = 1'b0;
          case (skt_pkg::op_e'(s_axis_tuser))
            skt_pkg::OP_INSERT: begin
              if (count_q >= CapCnt) begin
                out_load = 1'b1;
                out_d    = make_out(skt_pkg::ST_FULL, '0, '0, 1'b1);
              end else if (count_q == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = in_entry;
                count_d   = CW'(1);
                out_load  = 1'b1;
                out_d     = make_out(skt_pkg::ST_OK, '0, in_entry, 1'b1);
              end else begin
                idx_d   = last_idx;
                state_d = skt_pkg::S_INS;
              end
            end
            skt_pkg::OP_DELETE, skt_pkg::OP_SEARCH: begin
              if (count_q == '0) begin
                out_load = 1'b1;
                out_d    = make_out(skt_pkg::ST_EMPTY, '0, '0, 1'b1);
              end else begin
                idx_d   = '0;
                state_d = skt_pkg::S_SCAN;
              end
            end
            skt_pkg::OP_LIST: begin
              if (count_q == '0) begin
                out_load = 1'b1;
                out_d    = make_out(skt_pkg::ST_EMPTY, '0, '0, 1'b1);
              end else begin
                idx_d   = '0;
                state_d = skt_pkg::S_LIST;
              end
            end
            default: begin
              state_d = skt_pkg::S_IDLE;
            end
          endcase
        end
      end

      // walk down, moving larger-or-equal entries up one slot
      skt_pkg::S_INS: begin
        if (cmp.key_le) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q + IW'(1);
          mem_wdata = rdata;
          if (idx_q == '0) begin
            state_d = skt_pkg::S_PUT;
          end else begin
            idx_d = idx_q - IW'(1);
          end
        end else if (out_free) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q + IW'(1);
          mem_wdata = new_entry;
          count_d   = count_q + CW'(1);
          out_load  = 1'b1;
          out_d     = make_out(skt_pkg::ST_OK, idx_q + IW'(1), new_entry, 1'b1);
          state_d   = skt_pkg::S_IDLE;
        end
      end

      // new entry goes to the bottom slot
      skt_pkg::S_PUT: begin
        if (out_free) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = new_entry;
          count_d   = count_q + CW'(1);
          out_load  = 1'b1;
          out_d     = make_out(skt_pkg::ST_OK, '0, new_entry, 1'b1);
          state_d   = skt_pkg::S_IDLE;
        end
      end

      // walk up looking for the name; on delete close the gap in the same pass
      skt_pkg::S_SCAN: begin
        if (found_q) begin
          if (!at_last) begin
            mem_we    = 1'b1;
            mem_waddr = idx_q - IW'(1);
            idx_d     = idx_q + IW'(1);
          end else if (out_free) begin
            mem_we    = 1'b1;
            mem_waddr = idx_q - IW'(1);
            count_d   = count_q - CW'(1);
            out_load  = 1'b1;
            out_d     = make_out(skt_pkg::ST_OK, hit_pos_q, hit_q, 1'b1);
            state_d   = skt_pkg::S_IDLE;
          end
        end else if (cmp.tag_eq) begin
          if (op_q == skt_pkg::OP_SEARCH) begin
            if (out_free) begin
              out_load = 1'b1;
              out_d    = make_out(skt_pkg::ST_OK, idx_q, rdata, 1'b1);
              state_d  = skt_pkg::S_IDLE;
            end
          end else if (!at_last) begin
            found_d   = 1'b1;
            hit_pos_d = idx_q;
            hit_d     = rdata;
            idx_d     = idx_q + IW'(1);
          end else if (out_free) begin
            count_d  = count_q - CW'(1);
            out_load = 1'b1;
            out_d    = make_out(skt_pkg::ST_OK, idx_q, rdata, 1'b1);
            state_d  = skt_pkg::S_IDLE;
          end
        end else if (!at_last) begin
          idx_d = idx_q + IW'(1);
        end else if (out_free) begin
          out_load = 1'b1;
          out_d    = make_out(skt_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
          state_d  = skt_pkg::S_IDLE;
        end
      end

      // one entry per output transaction
      skt_pkg::S_LIST: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = make_out(skt_pkg::ST_OK, idx_q, rdata, at_last);
          if (at_last) begin
            state_d = skt_pkg::S_IDLE;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end

      default: begin
        state_d = skt_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  assign m_valid_d = out_load || (m_valid_q && !m_axis_tready);
  assign tot_d     = out_load ? skt_pkg::TotW'(count_d) : tot_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= skt_pkg::S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      found_q   <= found_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    op_q      <= op_d;
    key_q     <= key_d;
    tag_q     <= tag_d;
    hit_pos_q <= hit_pos_d;
    hit_q     <= hit_d;
    out_q     <= out_d;
    tot_q     <= tot_d;
  end

  // port packing
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {{PadW{1'b0}}, tot_q, out_q.name, out_q.id, out_q.pos};

  // entry count never exceeds the table size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count above capacity");

  // the walk index stays inside the stored entries
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != skt_pkg::S_IDLE) |-> (idx_q <= last_idx))
    else $error("walk index outside stored entries");

  // the table changes size only together with a result
  a_count_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(count_q))
    else $error("entry count changed without a result");

  // no memory write while idle without an accepted transaction
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == skt_pkg::S_IDLE) && !s_accept) |-> !mem_we)
    else $error("memory written while idle");

  // a list of a non-empty table starts the list walk
  a_list_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && (s_axis_tuser == skt_pkg::OP_LIST) && (count_q != '0))
      |=> (state_q == skt_pkg::S_LIST))
    else $error("list transaction did not start the walk");

endmodule

@@ rtl/skt_mem.sv @@
// entry storage: one write port, one read port with registered read data
module skt_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  skt_pkg::entry_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output skt_pkg::entry_t rdata_o
);

  skt_pkg::entry_t mem_q [DEPTH];
  skt_pkg::entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/skt_cmp.sv @@
// shared compare unit: signed key order and name tag match
module skt_cmp (
  input  logic [skt_pkg::KeyW-1:0] key_a_i,
  input  logic [skt_pkg::KeyW-1:0] key_b_i,
  input  logic [skt_pkg::TagW-1:0] tag_a_i,
  input  logic [skt_pkg::TagW-1:0] tag_b_i,
  output skt_pkg::cmp_res_t        res_o
);

  // new key sorts at or before the stored key
  assign res_o.key_le = $signed(key_a_i) <= $signed(key_b_i);
  // stored name equals the requested name
  assign res_o.tag_eq = (tag_a_i == tag_b_i);

endmodule
